[src/vrst_pkg.sv]
// vrst_pkg: shared constants, types and a helper function for the vertex transform block.
// Depends on nothing; imported by every module in src.
`timescale 1ns / 1ps

package vrst_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int ANGLE_WIDTH_DEF = 16;
    localparam int CORDIC_STEPS    = 18;
    localparam int TRIG_WIDTH      = 32;   // Q1.30 with sign and headroom
    localparam int ZW              = 24;   // CORDIC residual angle width

    localparam logic signed [TRIG_WIDTH-1:0] CORDIC_ONE = 32'sd652032874;
    localparam logic signed [TRIG_WIDTH-1:0] TRIG_ONE   = 32'sd1073741824;

    localparam int SCALE_WIDTH = 32;
    localparam int APB_ADDR_W  = 6;        // 7 registers at 8-byte stride

    typedef enum logic [2:0] {
        REG_ANGLES   = 3'd0,
        REG_SCALE_X  = 3'd1,
        REG_SCALE_Y  = 3'd2,
        REG_SCALE_Z  = 3'd3,
        REG_OFFSET_X = 3'd4,
        REG_OFFSET_Y = 3'd5,
        REG_OFFSET_Z = 3'd6
    } reg_idx_t;

    function automatic logic signed [ZW-1:0] atan_turn(input int i);
        case (i)
            0:  atan_turn = 24'sd2097152;
            1:  atan_turn = 24'sd1238021;
            2:  atan_turn = 24'sd654136;
            3:  atan_turn = 24'sd332050;
            4:  atan_turn = 24'sd166669;
            5:  atan_turn = 24'sd83416;
            6:  atan_turn = 24'sd41718;
            7:  atan_turn = 24'sd20860;
            8:  atan_turn = 24'sd10430;
            9:  atan_turn = 24'sd5215;
            10: atan_turn = 24'sd2608;
            11: atan_turn = 24'sd1304;
            12: atan_turn = 24'sd652;
            13: atan_turn = 24'sd326;
            14: atan_turn = 24'sd163;
            15: atan_turn = 24'sd81;
            16: atan_turn = 24'sd41;
            default: atan_turn = 24'sd20;
        endcase
    endfunction

    typedef struct packed {
        logic signed [TRIG_WIDTH-1:0] c;
        logic signed [TRIG_WIDTH-1:0] s;
    } trig_t;

endpackage

[src/vertex_rotate_scale_translate_top.sv]
// Vertex rotate/scale/translate: rotate x,y,z, scale per axis, offset, saturate.
// One vertex per cycle while the output is not stalled and no CORDIC run is busy.
// Pipeline advances whenever the output stage is empty or being taken.
// Input held off after reset and after an angle write that changes an angle (CORDIC runs).
// rst_n asynchronously clears valid bits and loads register reset values.
// Depends on vrst_pkg, vrst_sincos, vrst_rotate, vrst_mulrnd.
`timescale 1ns / 1ps

module vertex_rotate_scale_translate_top
    import vrst_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_W-1:0]         paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] x_in,
    input  logic signed [COORD_WIDTH-1:0] y_in,
    input  logic signed [COORD_WIDTH-1:0] z_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] x_out,
    output logic signed [COORD_WIDTH-1:0] y_out,
    output logic signed [COORD_WIDTH-1:0] z_out,
    output logic                          overflow
);

    localparam int CW    = COORD_WIDTH;
    localparam int DEPTH = 13;
    localparam int SPW   = CW + SCALE_WIDTH - 16 + 1;
    localparam logic signed [SPW:0] SHI =
        $signed({{(SPW+1-CW){1'b0}}, {1'b0, {(CW-1){1'b1}}}});
    localparam logic signed [SPW:0] SLO = -SHI - 1;
    localparam logic signed [CW:0] OHI = $signed({2'b00, {(CW-1){1'b1}}});
    localparam logic signed [CW:0] OLO = -OHI - 1;

    logic [47:0]                    angles_reg;
    logic signed [SCALE_WIDTH-1:0]  scale_reg [3];
    logic signed [CW-1:0]           offset_reg [3];
    reg_idx_t                       widx;
    logic                           wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign widx   = reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angles_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                scale_reg[i]  <= SCALE_WIDTH'(65536);
                offset_reg[i] <= '0;
            end
        end
        else if (wr)
        begin
            case (widx)
                REG_ANGLES:   angles_reg    <= pwdata[47:0];
                REG_SCALE_X:  scale_reg[0]  <= pwdata[SCALE_WIDTH-1:0];
                REG_SCALE_Y:  scale_reg[1]  <= pwdata[SCALE_WIDTH-1:0];
                REG_SCALE_Z:  scale_reg[2]  <= pwdata[SCALE_WIDTH-1:0];
                REG_OFFSET_X: offset_reg[0] <= pwdata[CW-1:0];
                REG_OFFSET_Y: offset_reg[1] <= pwdata[CW-1:0];
                REG_OFFSET_Z: offset_reg[2] <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (widx)
            REG_ANGLES:   prdata = 64'(angles_reg);
            REG_SCALE_X:  prdata = 64'($unsigned(scale_reg[0]));
            REG_SCALE_Y:  prdata = 64'($unsigned(scale_reg[1]));
            REG_SCALE_Z:  prdata = 64'($unsigned(scale_reg[2]));
            REG_OFFSET_X: prdata = 64'($unsigned(offset_reg[0]));
            REG_OFFSET_Y: prdata = 64'($unsigned(offset_reg[1]));
            REG_OFFSET_Z: prdata = 64'($unsigned(offset_reg[2]));
            default:      prdata = '0;
        endcase
    end

    trig_t trig_x, trig_y, trig_z;
    logic  busy_x, busy_y, busy_z;

    vrst_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_sc_x
        (.clk(clk), .rst_n(rst_n), .angle(angles_reg[15:0]),  .trig(trig_x), .busy(busy_x));
    vrst_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_sc_y
        (.clk(clk), .rst_n(rst_n), .angle(angles_reg[31:16]), .trig(trig_y), .busy(busy_y));
    vrst_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_sc_z
        (.clk(clk), .rst_n(rst_n), .angle(angles_reg[47:32]), .trig(trig_z), .busy(busy_z));

    // Single global enable: whole pipe moves unless the output beat is stuck.
    logic             en;
    logic [DEPTH-1:0] vld_reg;

    assign en        = !out_valid || out_ready;
    assign in_ready  = en && !(busy_x || busy_y || busy_z);
    assign out_valid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid && in_ready};
    end

    // rotation about x: (y,z); about y: (z,x); about z: (x,y)
    logic signed [CW-1:0] y1, z1, x1, z2, x2, y2, x3, y3, z3;
    logic                 o1, o2, o3;

    vrst_rotate #(.CW(CW)) u_rot_x
        (.clk(clk), .en(en), .trig(trig_x), .p(y_in), .q(z_in), .r(x_in), .ovf(1'b0),
         .p_out(y1), .q_out(z1), .r_out(x1), .ovf_out(o1));
    vrst_rotate #(.CW(CW)) u_rot_y
        (.clk(clk), .en(en), .trig(trig_y), .p(z1), .q(x1), .r(y1), .ovf(o1),
         .p_out(z2), .q_out(x2), .r_out(y2), .ovf_out(o2));
    vrst_rotate #(.CW(CW)) u_rot_z
        (.clk(clk), .en(en), .trig(trig_z), .p(x2), .q(y2), .r(z2), .ovf(o2),
         .p_out(x3), .q_out(y3), .r_out(z3), .ovf_out(o3));

    // scale: multiply, clamp, then offset and clamp, each registered
    logic signed [CW-1:0] c3 [3];
    logic signed [SPW-1:0] sp [3];
    logic signed [CW-1:0] sc_reg [3];
    logic signed [CW-1:0] res_reg [3];
    logic                 sat_sv [3];
    logic                 sat_ov [3];
    logic                 o_d1_reg, o_d2_reg, o_sc_reg, o_res_reg;

    assign c3[0] = x3;
    assign c3[1] = y3;
    assign c3[2] = z3;

    for (genvar k = 0; k < 3; k++)
    begin : g_scale
        logic signed [SPW:0] spx;
        logic signed [CW:0]  sum;
        vrst_mulrnd #(.AW(CW), .BW(SCALE_WIDTH), .SH(16)) u_mul
            (.clk(clk), .en(en), .a(c3[k]), .b(scale_reg[k]), .p(sp[k]));
        assign spx = {sp[k][SPW-1], sp[k]};
        assign sum = {sc_reg[k][CW-1], sc_reg[k]} + {offset_reg[k][CW-1], offset_reg[k]};
        assign sat_sv[k] = (spx > SHI) || (spx < SLO);
        assign sat_ov[k] = (sum > OHI) || (sum < OLO);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sc_reg[k]  <= (spx > SHI) ? SHI[CW-1:0] : (spx < SLO) ? SLO[CW-1:0]
                                                                   : spx[CW-1:0];
                res_reg[k] <= (sum > OHI) ? OHI[CW-1:0] : (sum < OLO) ? OLO[CW-1:0]
                                                                   : sum[CW-1:0];
            end
        end
    end

    logic sat_s, sat_o;
    assign sat_s = sat_sv[0] || sat_sv[1] || sat_sv[2];
    assign sat_o = sat_ov[0] || sat_ov[1] || sat_ov[2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_d1_reg  <= o3;
            o_d2_reg  <= o_d1_reg;
            o_sc_reg  <= o_d2_reg | sat_s;
            o_res_reg <= o_sc_reg | sat_o;
        end
    end

    assign x_out    = res_reg[0];
    assign y_out    = res_reg[1];
    assign z_out    = res_reg[2];
    assign overflow = o_res_reg;

endmodule

[src/vrst_sincos.sv]
// vrst_sincos: iterative CORDIC sine/cosine of one binary angle from config, one step per cycle.
// Restarts whenever the angle changes; busy stays high until the new result is latched.
// Depends on vrst_pkg.
`timescale 1ns / 1ps

module vrst_sincos
    import vrst_pkg::*;
#(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] angle,
    output trig_t       trig,
    output logic        busy
);

    localparam int STEP_W = 5;

    logic [ZW-1:0]                a;
    logic [1:0]                   quad;
    logic                         restart;
    logic [15:0]                  angle_reg;
    logic                         busy_reg;
    logic [STEP_W-1:0]            step_reg;
    logic signed [TRIG_WIDTH-1:0] x_reg, y_reg, x_next, y_next, xc, yc;
    logic signed [ZW-1:0]         z_reg, z_next;
    trig_t                        trig_next, trig_reg;

    assign a       = ZW'(angle[15 -: ANGLE_WIDTH]) << (ZW - ANGLE_WIDTH);
    assign quad    = angle_reg[15:14];
    assign restart = angle != angle_reg;
    assign busy    = busy_reg || restart;

    always_comb
    begin
        if (!z_reg[ZW-1])
        begin
            x_next = x_reg - (y_reg >>> step_reg);
            y_next = y_reg + (x_reg >>> step_reg);
            z_next = z_reg - atan_turn(int'(step_reg));
        end
        else
        begin
            x_next = x_reg + (y_reg >>> step_reg);
            y_next = y_reg - (x_reg >>> step_reg);
            z_next = z_reg + atan_turn(int'(step_reg));
        end
    end

    always_comb
    begin
        xc = x_reg;
        yc = y_reg;
        if (xc > TRIG_ONE)  xc = TRIG_ONE;
        if (xc < -TRIG_ONE) xc = -TRIG_ONE;
        if (yc > TRIG_ONE)  yc = TRIG_ONE;
        if (yc < -TRIG_ONE) yc = -TRIG_ONE;
        case (quad)
            2'd0:    begin trig_next.c = xc;  trig_next.s = yc;  end
            2'd1:    begin trig_next.c = -yc; trig_next.s = xc;  end
            2'd2:    begin trig_next.c = -xc; trig_next.s = -yc; end
            default: begin trig_next.c = yc;  trig_next.s = -xc; end
        endcase
    end

    // reset starts a run for angle zero, matching the angle register reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg <= '0;
            busy_reg  <= 1'b1;
            step_reg  <= '0;
            x_reg     <= CORDIC_ONE;
            y_reg     <= '0;
            z_reg     <= '0;
            trig_reg  <= '{c: TRIG_ONE, s: '0};
        end
        else if (restart)
        begin
            angle_reg <= angle;
            busy_reg  <= 1'b1;
            step_reg  <= '0;
            x_reg     <= CORDIC_ONE;
            y_reg     <= '0;
            z_reg     <= $signed({2'b00, a[ZW-3:0]});
        end
        else if (busy_reg)
        begin
            if (step_reg == STEP_W'(CORDIC_STEPS))
            begin
                trig_reg <= trig_next;
                busy_reg <= 1'b0;
            end
            else
            begin
                x_reg    <= x_next;
                y_reg    <= y_next;
                z_reg    <= z_next;
                step_reg <= step_reg + STEP_W'(1);
            end
        end
    end

    assign trig = trig_reg;

endmodule

[src/vrst_mulrnd.sv]
// vrst_mulrnd: one registered signed multiply with round-half-away and shift.
// Depends on vrst_pkg. Product and rounded result are each registered, gated by an enable for stalls.
`timescale 1ns / 1ps

module vrst_mulrnd
    import vrst_pkg::*;
#(
    parameter int AW = 32,
    parameter int BW = 32,
    parameter int SH = 30
)(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic signed [AW+BW-SH:0] p
);

    logic signed [AW+BW-1:0] prod_reg;
    logic        [AW+BW-1:0] mag;
    logic        [AW+BW-1:0] rnd;
    logic signed [AW+BW-SH:0] p_reg;

    always_comb
    begin
        mag = prod_reg[AW+BW-1] ? (AW+BW)'(-prod_reg) : (AW+BW)'(prod_reg);
        rnd = (mag + ((AW+BW)'(1) << (SH - 1))) >> SH;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
            p_reg    <= prod_reg[AW+BW-1] ? -$signed({1'b0, rnd[AW+BW-SH-1:0]})
                                          :  $signed({1'b0, rnd[AW+BW-SH-1:0]});
        end
    end

    assign p = p_reg;

endmodule

[src/vrst_rotate.sv]
// vrst_rotate: one plane rotation stage (p,q)->(pc-qs, ps+qc), saturated.
// Depends on vrst_pkg and vrst_mulrnd. All outputs are registered.
`timescale 1ns / 1ps

module vrst_rotate
    import vrst_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF
)(
    input  logic                 clk,
    input  logic                 en,
    input  trig_t                trig,
    input  logic signed [CW-1:0] p,
    input  logic signed [CW-1:0] q,
    input  logic signed [CW-1:0] r,
    input  logic                 ovf,
    output logic signed [CW-1:0] p_out,
    output logic signed [CW-1:0] q_out,
    output logic signed [CW-1:0] r_out,
    output logic                 ovf_out
);

    localparam int PW = CW + TRIG_WIDTH - 30 + 1;
    localparam logic signed [PW:0] HI = PW'(1) <<< 0 == 0 ? '0 :
        $signed({{(PW+1-CW){1'b0}}, {1'b0, {(CW-1){1'b1}}}});
    localparam logic signed [PW:0] LO = -HI - 1;

    logic signed [PW-1:0] pc, qs, ps, qc;
    logic signed [PW:0]   np, nq;
    logic signed [CW-1:0] r_d1_reg, r_d2_reg, r_reg, p_reg, q_reg;
    logic                 o_d1_reg, o_d2_reg, o_reg;

    vrst_mulrnd #(.AW(CW), .BW(TRIG_WIDTH), .SH(30)) u_pc
        (.clk(clk), .en(en), .a(p), .b(trig.c), .p(pc));
    vrst_mulrnd #(.AW(CW), .BW(TRIG_WIDTH), .SH(30)) u_qs
        (.clk(clk), .en(en), .a(q), .b(trig.s), .p(qs));
    vrst_mulrnd #(.AW(CW), .BW(TRIG_WIDTH), .SH(30)) u_ps
        (.clk(clk), .en(en), .a(p), .b(trig.s), .p(ps));
    vrst_mulrnd #(.AW(CW), .BW(TRIG_WIDTH), .SH(30)) u_qc
        (.clk(clk), .en(en), .a(q), .b(trig.c), .p(qc));

    assign np = {pc[PW-1], pc} - {qs[PW-1], qs};
    assign nq = {ps[PW-1], ps} + {qc[PW-1], qc};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_d1_reg <= r;
            r_d2_reg <= r_d1_reg;
            r_reg    <= r_d2_reg;
            o_d1_reg <= ovf;
            o_d2_reg <= o_d1_reg;
            p_reg    <= (np > HI) ? HI[CW-1:0] : (np < LO) ? LO[CW-1:0] : np[CW-1:0];
            q_reg    <= (nq > HI) ? HI[CW-1:0] : (nq < LO) ? LO[CW-1:0] : nq[CW-1:0];
            o_reg    <= o_d2_reg | (np > HI) | (np < LO) | (nq > HI) | (nq < LO);
        end
    end

    assign p_out   = p_reg;
    assign q_out   = q_reg;
    assign r_out   = r_reg;
    assign ovf_out = o_reg;

endmodule

[src/vrst_checker.sv]
// vrst_checker: port-level checks on the vertex transform top, bound below.
// Depends on vrst_pkg (imported, no items used).
`timescale 1ns / 1ps

module vrst_checker
    import vrst_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [31:0] x_out,
    input logic pready
);

    // stalled output beat stays valid and holds its x payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(x_out))
        else $error("output beat changed while stalled");

    // an input beat is only taken while the output side moves
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !out_valid || out_ready)
        else $error("input beat taken with output side stuck");

    // stall on output blocks input
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken during output stall");

    a_pready: assert property (@(posedge clk) pready)
        else $error("pready low");

endmodule

bind vertex_rotate_scale_translate_top vrst_checker u_vrst_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .x_out(x_out[31:0]), .pready(pready)
);
